@@ hw/rtl/axis_angle_rotation_matrix_top_assert.svh @@
// ============================================================================
// axis_angle_rotation_matrix_top_assert.svh
// assertion macros for the rotation matrix rtl, used by aarm_skid
// ============================================================================
`ifndef AXIS_ANGLE_ROTATION_MATRIX_TOP_ASSERT_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define AARM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define AARM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/aarm_pkg.sv @@
// ============================================================================
// aarm_pkg
// widths, constants and shared types of the axis-angle rotation matrix
// ============================================================================
package aarm_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int FRAC_BITS    = 14;
    localparam int ATAN_LEN     = 24;
    localparam int N_STEPS      = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

    // field widths
    localparam int AXIS_W     = 16;
    localparam int ANG_W      = 16;
    localparam int MAT_W      = 16;
    localparam int IN_DATA_W  = 3 * AXIS_W + ANG_W;
    localparam int MAT_DATA_W = 9 * MAT_W;

    // q3.13 angle to q2.30
    localparam int ANG_SHIFT = 17;

    // internal widths
    localparam int Z_W     = 34;
    localparam int X_W     = 33;
    localparam int OMC_W   = 34;
    localparam int P_W     = 2 * AXIS_W;
    localparam int OL_W    = 17;
    localparam int OH_W    = OMC_W - OL_W;
    localparam int HI_W    = P_W + OH_W;
    localparam int LO_W    = P_W + OL_W + 1;
    localparam int SIDE_W  = AXIS_W + X_W;
    localparam int PROD_W  = 64;
    localparam int T_W     = PROD_W - FRAC_BITS;
    localparam int CD_W    = X_W + FRAC_BITS;
    localparam int ACC_W   = ((T_W > CD_W) ? T_W : CD_W) + 2;
    localparam int RND_SHIFT = 30;
    localparam int R_W     = ACC_W - RND_SHIFT;

    localparam logic signed [X_W-1:0]   GAIN_Q30    = 33'sd652032874;
    localparam logic signed [OMC_W-1:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [Z_W-1:0]   PI_Q30      = 34'sd3373259426;
    localparam logic signed [Z_W-1:0]   HALF_PI_Q30 = 34'sd1686629713;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (RND_SHIFT - 1);
    localparam logic signed [R_W-1:0]   SAT_HI     = R_W'(32'sd32767);
    localparam logic signed [R_W-1:0]   SAT_LO     = R_W'(-32'sd32768);

    // arctan(2^-i) in q2.30, rounded to nearest
    localparam logic signed [Z_W-1:0] ATAN_Q30 [ATAN_LEN] = '{
        34'sd843314857, 34'sd497837830, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128
    };

    // cordic result travelling to the matrix stages
    typedef struct packed {
        logic                     valid;
        logic                     neg;
        logic signed [X_W-1:0]    x;
        logic signed [X_W-1:0]    y;
        logic signed [AXIS_W-1:0] ux;
        logic signed [AXIS_W-1:0] uy;
        logic signed [AXIS_W-1:0] uz;
    } t_rot;

    // finished matrix entering the output buffer, m0 in the low bits
    typedef struct packed {
        logic                  valid;
        logic [MAT_DATA_W-1:0] data;
    } t_res;

    // round half up at bit 30 and clamp to a 16-bit entry
    function automatic logic [MAT_W-1:0] rnd_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] a;
        logic signed [R_W-1:0]   r;
        logic [MAT_W-1:0]        q;
        a = acc + ROUND_HALF;
        r = a[ACC_W-1:RND_SHIFT];
        if (r > SAT_HI) begin
            q = SAT_HI[MAT_W-1:0];
        end else if (r < SAT_LO) begin
            q = SAT_LO[MAT_W-1:0];
        end else begin
            q = r[MAT_W-1:0];
        end
        return q;
    endfunction

endpackage

@@ hw/rtl/aarm_cordic.sv @@
// ============================================================================
// aarm_cordic
// quadrant fold and one cordic micro-rotation per pipeline stage
// ============================================================================
module aarm_cordic (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  logic signed [aarm_pkg::AXIS_W-1:0] i_ux,
    input  logic signed [aarm_pkg::AXIS_W-1:0] i_uy,
    input  logic signed [aarm_pkg::AXIS_W-1:0] i_uz,
    input  logic signed [aarm_pkg::ANG_W-1:0]  i_angle,
    output aarm_pkg::t_rot                o_rot
);
    import aarm_pkg::*;

    logic                     r_v   [0:N_STEPS];
    logic                     r_neg [0:N_STEPS];
    logic signed [X_W-1:0]    r_x   [0:N_STEPS];
    logic signed [X_W-1:0]    r_y   [0:N_STEPS];
    logic signed [Z_W-1:0]    r_z   [0:N_STEPS];
    logic signed [AXIS_W-1:0] r_ux  [0:N_STEPS];
    logic signed [AXIS_W-1:0] r_uy  [0:N_STEPS];
    logic signed [AXIS_W-1:0] r_uz  [0:N_STEPS];

    logic signed [Z_W-1:0] w_ang;
    logic signed [Z_W-1:0] n_z0;
    logic                  n_neg0;

    assign w_ang = $signed({i_angle[ANG_W-1], i_angle, {ANG_SHIFT{1'b0}}});

    // fold into +/- pi/2, cos and sin get negated at the end
    always_comb begin
        n_z0   = w_ang;
        n_neg0 = 1'b0;
        if (w_ang > HALF_PI_Q30) begin
            n_z0   = w_ang - PI_Q30;
            n_neg0 = 1'b1;
        end else if (w_ang < -HALF_PI_Q30) begin
            n_z0   = w_ang + PI_Q30;
            n_neg0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_adv) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_neg[0] <= n_neg0;
            r_x[0]   <= GAIN_Q30;
            r_y[0]   <= '0;
            r_z[0]   <= n_z0;
            r_ux[0]  <= i_ux;
            r_uy[0]  <= i_uy;
            r_uz[0]  <= i_uz;
        end
    end

    for (genvar i = 0; i < N_STEPS; i++) begin : g_step
        logic signed [X_W-1:0] w_dx;
        logic signed [X_W-1:0] w_dy;

        assign w_dx = r_y[i] >>> i;
        assign w_dy = r_x[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_adv) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                if (!r_z[i][Z_W-1]) begin
                    r_x[i+1] <= r_x[i] - w_dx;
                    r_y[i+1] <= r_y[i] + w_dy;
                    r_z[i+1] <= r_z[i] - ATAN_Q30[i];
                end else begin
                    r_x[i+1] <= r_x[i] + w_dx;
                    r_y[i+1] <= r_y[i] - w_dy;
                    r_z[i+1] <= r_z[i] + ATAN_Q30[i];
                end
                r_neg[i+1] <= r_neg[i];
                r_ux[i+1]  <= r_ux[i];
                r_uy[i+1]  <= r_uy[i];
                r_uz[i+1]  <= r_uz[i];
            end
        end
    end

    assign o_rot.valid = r_v[N_STEPS];
    assign o_rot.neg   = r_neg[N_STEPS];
    assign o_rot.x     = r_x[N_STEPS];
    assign o_rot.y     = r_y[N_STEPS];
    assign o_rot.ux    = r_ux[N_STEPS];
    assign o_rot.uy    = r_uy[N_STEPS];
    assign o_rot.uz    = r_uz[N_STEPS];

endmodule

@@ hw/rtl/aarm_entry.sv @@
// ============================================================================
// aarm_entry
// matrix entries from cos and sin: products, split multiply, sum, round
// ============================================================================
module aarm_entry (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  aarm_pkg::t_rot i_rot,
    output aarm_pkg::t_res o_res
);
    import aarm_pkg::*;

    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_XY = 3;
    localparam int P_XZ = 4;
    localparam int P_YZ = 5;
    localparam int N_P  = 6;

    // stage 1: signs restored, 1-cos, axis products
    logic                     r_v1;
    logic signed [X_W-1:0]    r_c1;
    logic signed [X_W-1:0]    r_s1;
    logic signed [OMC_W-1:0]  r_omc1;
    logic signed [P_W-1:0]    r_p1 [N_P];
    logic signed [AXIS_W-1:0] r_ux1;
    logic signed [AXIS_W-1:0] r_uy1;
    logic signed [AXIS_W-1:0] r_uz1;

    // stage 2: partial products and sine terms
    logic                     r_v2;
    logic signed [HI_W-1:0]   r_hi2 [N_P];
    logic signed [LO_W-1:0]   r_lo2 [N_P];
    logic signed [SIDE_W-1:0] r_sx2;
    logic signed [SIDE_W-1:0] r_sy2;
    logic signed [SIDE_W-1:0] r_sz2;
    logic signed [CD_W-1:0]   r_cd2;

    // stage 3: floor-shifted products
    logic                     r_v3;
    logic signed [T_W-1:0]    r_t3 [N_P];
    logic signed [SIDE_W-1:0] r_sx3;
    logic signed [SIDE_W-1:0] r_sy3;
    logic signed [SIDE_W-1:0] r_sz3;
    logic signed [CD_W-1:0]   r_cd3;

    logic signed [X_W-1:0]    n_c1;
    logic signed [X_W-1:0]    n_s1;
    logic signed [OMC_W-1:0]  n_omc1;
    logic signed [OH_W-1:0]   w_oh;
    logic signed [OL_W:0]     w_ol;
    logic signed [ACC_W-1:0]  w_t [N_P];
    logic signed [ACC_W-1:0]  w_cd;
    logic signed [ACC_W-1:0]  w_sx;
    logic signed [ACC_W-1:0]  w_sy;
    logic signed [ACC_W-1:0]  w_sz;
    logic [MAT_W-1:0]         w_m [9];

    always_comb begin
        n_c1   = i_rot.neg ? -i_rot.x : i_rot.x;
        n_s1   = i_rot.neg ? -i_rot.y : i_rot.y;
        n_omc1 = i_rot.neg ? ONE_Q30 + OMC_W'(i_rot.x) : ONE_Q30 - OMC_W'(i_rot.x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_rot.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_c1       <= n_c1;
            r_s1       <= n_s1;
            r_omc1     <= n_omc1;
            r_p1[P_XX] <= i_rot.ux * i_rot.ux;
            r_p1[P_YY] <= i_rot.uy * i_rot.uy;
            r_p1[P_ZZ] <= i_rot.uz * i_rot.uz;
            r_p1[P_XY] <= i_rot.ux * i_rot.uy;
            r_p1[P_XZ] <= i_rot.ux * i_rot.uz;
            r_p1[P_YZ] <= i_rot.uy * i_rot.uz;
            r_ux1      <= i_rot.ux;
            r_uy1      <= i_rot.uy;
            r_uz1      <= i_rot.uz;
        end
    end

    // 1-cos split into a signed high half and an unsigned low half
    assign w_oh = r_omc1[OMC_W-1:OL_W];
    assign w_ol = $signed({1'b0, r_omc1[OL_W-1:0]});

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < N_P; k++) begin
                r_hi2[k] <= r_p1[k] * w_oh;
                r_lo2[k] <= r_p1[k] * w_ol;
            end
            r_sx2 <= r_ux1 * r_s1;
            r_sy2 <= r_uy1 * r_s1;
            r_sz2 <= r_uz1 * r_s1;
            r_cd2 <= $signed({r_c1, {FRAC_BITS{1'b0}}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < N_P; k++) begin
                r_t3[k] <= T_W'(((PROD_W'(r_hi2[k]) <<< OL_W) + PROD_W'(r_lo2[k]))
                                >>> FRAC_BITS);
            end
            r_sx3 <= r_sx2;
            r_sy3 <= r_sy2;
            r_sz3 <= r_sz2;
            r_cd3 <= r_cd2;
        end
    end

    // final sums, rounding and clamp feed the output buffer directly
    always_comb begin
        for (int k = 0; k < N_P; k++) begin
            w_t[k] = ACC_W'(r_t3[k]);
        end
        w_cd = ACC_W'(r_cd3);
        w_sx = ACC_W'(r_sx3);
        w_sy = ACC_W'(r_sy3);
        w_sz = ACC_W'(r_sz3);
        w_m[0] = rnd_sat(w_t[P_XX] + w_cd);
        w_m[1] = rnd_sat(w_t[P_XY] + w_sz);
        w_m[2] = rnd_sat(w_t[P_XZ] - w_sy);
        w_m[3] = rnd_sat(w_t[P_XY] - w_sz);
        w_m[4] = rnd_sat(w_t[P_YY] + w_cd);
        w_m[5] = rnd_sat(w_t[P_YZ] + w_sx);
        w_m[6] = rnd_sat(w_t[P_XZ] + w_sy);
        w_m[7] = rnd_sat(w_t[P_YZ] - w_sx);
        w_m[8] = rnd_sat(w_t[P_ZZ] + w_cd);
    end

    assign o_res.valid = r_v3;
    assign o_res.data  = {w_m[8], w_m[7], w_m[6], w_m[5], w_m[4],
                          w_m[3], w_m[2], w_m[1], w_m[0]};

endmodule

@@ hw/rtl/aarm_skid.sv @@
// ============================================================================
// aarm_skid
// output register with one skid entry, frees the pipeline from the sink
// ============================================================================
`include "axis_angle_rotation_matrix_top_assert.svh"

module aarm_skid (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  aarm_pkg::t_res                    i_res,
    output logic                              o_ready,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [aarm_pkg::MAT_DATA_W-1:0]   o_m_axis_tdata
);
    import aarm_pkg::*;

    logic                  r_out_valid;
    logic [MAT_DATA_W-1:0] r_out_data;
    logic                  r_skid_valid;
    logic [MAT_DATA_W-1:0] r_skid_data;
    logic                  w_load;

    // output register can take a new value this cycle
    assign w_load  = !r_out_valid || i_m_axis_tready;
    assign o_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_load) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_res.valid;
            end
        end else if (i_res.valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_res.data;
        end else if (!r_skid_valid) begin
            r_skid_data <= i_res.data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `AARM_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid entry held while output register empty")
    `AARM_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && i_m_axis_tready, r_out_valid && !r_skid_valid && (r_out_data == $past(r_skid_data)), "skid entry not moved to output")
    `AARM_ASSERT_NEXT(a_skid_catches, i_clk, i_rst_n, i_res.valid && o_ready && r_out_valid && !i_m_axis_tready, r_skid_valid && (r_skid_data == $past(i_res.data)), "result lost while output stalled")

endmodule

@@ hw/rtl/axis_angle_rotation_matrix_top.sv @@
// ============================================================================
// axis_angle_rotation_matrix_top
// axis-angle (rodrigues) rotation matrix, fully pipelined
// ============================================================================
// Takes a unit axis (x, y, z in signed q2.14) and an angle (signed q3.13
// radians) and returns the nine entries of the 3x3 rotation matrix in signed
// q2.14, rounded half up and clamped to 16 bits. Any angle is accepted: values
// beyond +/- pi/2 are folded by pi with cos and sin negated, and an axis that
// is not unit length goes through the same formula unnormalized. One
// transaction is taken every clock cycle while the skid entry is free. On its
// way to output valid an input transaction passes the fold stage, the cordic
// chain (one micro-rotation per stage), three multiply and sum stages and the
// output register. The block keeps no state and needs no time after reset
// beyond the reset itself. When the sink stalls, one more result lands in a
// skid entry and the whole pipeline then holds.
// ============================================================================
module axis_angle_rotation_matrix_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // axis_x [15:0], axis_y [31:16], axis_z [47:32], angle [63:48]
    input  logic [aarm_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // m0 [15:0], m1 [31:16], ... m8 [143:128]
    output logic [aarm_pkg::MAT_DATA_W-1:0]   o_m_axis_tdata
);
    import aarm_pkg::*;

    logic w_adv;
    t_rot w_rot;
    t_res w_res;

    // the whole pipeline moves together while the skid entry is free
    assign o_s_axis_tready = w_adv;

    aarm_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_s_axis_tvalid),
        .i_ux    ($signed(i_s_axis_tdata[AXIS_W-1:0])),
        .i_uy    ($signed(i_s_axis_tdata[2*AXIS_W-1:AXIS_W])),
        .i_uz    ($signed(i_s_axis_tdata[3*AXIS_W-1:2*AXIS_W])),
        .i_angle ($signed(i_s_axis_tdata[IN_DATA_W-1:3*AXIS_W])),
        .o_rot   (w_rot)
    );

    // cos/sin to matrix entries
    aarm_entry u_entry (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_rot   (w_rot),
        .o_res   (w_res)
    );

    // output register plus skid entry
    aarm_skid u_skid (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_res           (w_res),
        .o_ready         (w_adv),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

@@ dv/axis_angle_rotation_matrix_top_checker.sv @@
// ============================================================================
// axis_angle_rotation_matrix_top_checker
// predicts every rotation matrix and compares it with the output stream
// ============================================================================
// Watches both stream channels of the rotation matrix block. Each input
// transaction is turned into the expected nine entries by a bit-exact model
// of the fixed-point cordic and rodrigues sums; each output transaction is
// compared entry by entry with the oldest expected matrix.
// ============================================================================
module axis_angle_rotation_matrix_top_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // axis_x [15:0], axis_y [31:16], axis_z [47:32], angle [63:48]
    input  logic [aarm_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // m0 [15:0], m1 [31:16], ... m8 [143:128]
    input  logic [aarm_pkg::MAT_DATA_W-1:0] i_m_tdata,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     STEPS     = 16;
    localparam int     FRAC      = 14;
    localparam longint GAIN      = 64'sd652032874;
    localparam longint ONE       = 64'sd1073741824;
    localparam longint PI        = 64'sd3373259426;
    localparam longint HALF_PI   = 64'sd1686629713;
    localparam longint ENTRY_MAX = 64'sd32767;
    localparam longint ENTRY_MIN = -64'sd32768;

    localparam longint ARCTAN [24] = '{
        64'sd843314857, 64'sd497837830, 64'sd263043837, 64'sd133525159,
        64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
        64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
        64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
        64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
        64'sd1024,      64'sd512,       64'sd256,       64'sd128
    };

    typedef logic [8:0][15:0] t_matrix;

    t_matrix matrix_q [$];
    int      fail_count = 0;
    int      checked    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = matrix_q.size();
    assign o_checked    = checked;

    // angle in q2.30, folded by pi outside +/- pi/2
    function automatic void cordic_cos_sin(input longint ang, output longint c,
                                           output longint s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        x    = GAIN;
        y    = 0;
        z    = ang;
        flip = 1'b0;
        if (z > HALF_PI) begin
            z    = z - PI;
            flip = 1'b1;
        end else if (z < -HALF_PI) begin
            z    = z + PI;
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic [15:0] rodrigues_entry(input longint ua, input longint ub,
                                                    input longint omc, input longint diag,
                                                    input longint side);
        longint acc;
        acc = ((ua * ub * omc) >>> FRAC) + diag + side;
        acc = (acc + (longint'(1) <<< 29)) >>> 30;
        if (acc > ENTRY_MAX) begin
            acc = ENTRY_MAX;
        end
        if (acc < ENTRY_MIN) begin
            acc = ENTRY_MIN;
        end
        return acc[15:0];
    endfunction

    function automatic t_matrix predict_rotation(input logic [aarm_pkg::IN_DATA_W-1:0] d);
        longint  ux;
        longint  uy;
        longint  uz;
        longint  c;
        longint  s;
        longint  omc;
        longint  cd;
        t_matrix m;
        ux = longint'($signed(d[15:0]));
        uy = longint'($signed(d[31:16]));
        uz = longint'($signed(d[47:32]));
        cordic_cos_sin(longint'($signed(d[63:48])) * 131072, c, s);
        omc  = ONE - c;
        cd   = c * (longint'(1) <<< FRAC);
        m[0] = rodrigues_entry(ux, ux, omc, cd, 0);
        m[1] = rodrigues_entry(uy, ux, omc, 0, uz * s);
        m[2] = rodrigues_entry(uz, ux, omc, 0, -(uy * s));
        m[3] = rodrigues_entry(ux, uy, omc, 0, -(uz * s));
        m[4] = rodrigues_entry(uy, uy, omc, cd, 0);
        m[5] = rodrigues_entry(uz, uy, omc, 0, ux * s);
        m[6] = rodrigues_entry(ux, uz, omc, 0, uy * s);
        m[7] = rodrigues_entry(uy, uz, omc, 0, -(ux * s));
        m[8] = rodrigues_entry(uz, uz, omc, cd, 0);
        return m;
    endfunction

    always @(posedge i_clk) begin
        t_matrix want;
        t_matrix got;
        if (!i_rst_n) begin
            matrix_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                matrix_q.push_back(predict_rotation(i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (matrix_q.size() == 0) begin
                    $error("unexpected matrix %h", i_m_tdata);
                    fail_count++;
                end else begin
                    want = matrix_q.pop_front();
                    got  = t_matrix'(i_m_tdata);
                    checked++;
                    for (int k = 0; k < 9; k++) begin
                        if (got[k] !== want[k]) begin
                            $error("m%0d: expected %0d, actual %0d", k,
                                   $signed(want[k]), $signed(got[k]));
                            fail_count++;
                        end
                    end
                end
            end
        end
    end

endmodule

@@ dv/axis_angle_rotation_matrix_top_test.sv @@
// ============================================================================
// axis_angle_rotation_matrix_top_test
// stream test of the axis-angle rotation matrix block
// ============================================================================
// Feeds axes and angles through the input stream with random gaps, stalls the
// output stream at random, and lets the checker compare every matrix against
// its own fixed-point prediction. A directed set covers the angle folds, the
// angle and axis extremes and saturation; the random part is mostly unit axes
// with in-range angles; some use any angle, +/-1.0 axes or raw 16-bit fields.
// ============================================================================
module axis_angle_rotation_matrix_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS  = 880;
    localparam int CYCLE_LIMIT   = 400000;
    // drain margin on top of the pipeline depth
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_AT      = 250;
    localparam int STALL_CYCLES  = 150;
    localparam int PAUSE_AT      = 500;
    localparam int BURST_FIRST   = 600;
    localparam int BURST_LAST    = 700;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    // axis_x [15:0], axis_y [31:16], axis_z [47:32], angle [63:48]
    logic [aarm_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // m0 [15:0], m1 [31:16], ... m8 [143:128]
    logic [aarm_pkg::MAT_DATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending;
    int checked;
    int items_sent  = 0;
    int directed_n  = 0;
    int cycle_count = 0;

    axis_angle_rotation_matrix_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata)
    );

    axis_angle_rotation_matrix_top_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hard stop in case a handshake never completes
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("axis_angle_rotation_matrix_top: mismatch");
            $finish;
        end
    end

    // mostly back-to-back or short gaps, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rotation_item(input int ax, input int ay, input int az,
                                                  input int ang);
        return {ang[15:0], az[15:0], ay[15:0], ax[15:0]};
    endfunction

    // random direction scaled to a unit axis in q2.14
    function automatic logic [47:0] unit_axis();
        real vx;
        real vy;
        real vz;
        real n;
        int  ax;
        int  ay;
        int  az;
        vx = real'(int'($urandom_range(0, 2000)) - 1000);
        vy = real'(int'($urandom_range(0, 2000)) - 1000);
        vz = real'(int'($urandom_range(0, 2000)) - 1000);
        n  = $sqrt(vx * vx + vy * vy + vz * vz);
        if (n < 1.0) begin
            vx = 1000.0;
            n  = 1000.0;
        end
        ax = int'(vx / n * 16384.0);
        ay = int'(vy / n * 16384.0);
        az = int'(vz / n * 16384.0);
        return {az[15:0], ay[15:0], ax[15:0]};
    endfunction

    // offer one transaction after an optional idle gap, return once it is taken
    task automatic send_rotation(input logic [63:0] d, input bit allow_gap);
        int gap;
        gap = allow_gap ? idle_length() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // output side: random ready, one long hold-off, one stretch always ready
    initial begin
        bit stall_done;
        int len;
        stall_done    = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!stall_done && items_sent >= STALL_AT) begin
                // hold off long enough to fill the pipe and push back on the input
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (STALL_CYCLES - 1) @(negedge i_clk);
                stall_done = 1'b1;
            end else if (items_sent >= BURST_FIRST && items_sent < BURST_LAST) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 1) == 1) begin
                len = $urandom_range(1, 12);
                @(negedge i_clk);
                m_axis_tready <= 1'b1;
                repeat (len - 1) @(negedge i_clk);
            end else begin
                len = idle_length();
                if (len == 0) begin
                    len = 1;
                end
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (len - 1) @(negedge i_clk);
            end
        end
    end

    // input side: reset, directed corners, random rotations, drain, verdict
    initial begin
        logic [63:0] directed [$];
        logic [47:0] axis;
        int          r;
        int          ang;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // angle corners on unit axes: zero, +/- pi, and both sides of +/- pi/2
        directed.push_back(rotation_item(16384, 0, 0, 0));
        directed.push_back(rotation_item(0, 16384, 0, 25736));
        directed.push_back(rotation_item(0, 0, 16384, -25736));
        directed.push_back(rotation_item(16384, 0, 0, 12867));
        directed.push_back(rotation_item(16384, 0, 0, 12868));
        directed.push_back(rotation_item(0, 16384, 0, -12867));
        directed.push_back(rotation_item(0, 16384, 0, -12868));
        // angles beyond pi still fold to the true cos and sin
        directed.push_back(rotation_item(0, 0, 16384, 32767));
        directed.push_back(rotation_item(0, 0, -16384, -32768));
        // negative unit axes and a diagonal unit axis
        directed.push_back(rotation_item(-16384, 0, 0, 6434));
        directed.push_back(rotation_item(0, -16384, 0, -6434));
        directed.push_back(rotation_item(9459, 9459, 9459, 17157));
        // axes off unit length, run through unnormalized and saturating
        directed.push_back(rotation_item(0, 0, 0, 8000));
        directed.push_back(rotation_item(32767, 32767, 32767, 25736));
        directed.push_back(rotation_item(-32768, -32768, -32768, 32767));
        directed.push_back(rotation_item(32767, -32768, 32767, -32768));
        directed.push_back(rotation_item(-32768, 32767, -32768, 12868));
        directed.push_back(rotation_item(16384, 16384, 16384, 0));
        directed.push_back(rotation_item(-16384, 16384, -16384, -25736));
        directed.push_back(rotation_item(32767, 0, -32768, 1));
        directed_n = directed.size();
        foreach (directed[i]) begin
            send_rotation(directed[i], 1'b1);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // let the pipe empty completely once, then carry on
            if (items_sent == PAUSE_AT) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                wait (pending == 0);
            end
            r   = $urandom_range(0, 99);
            ang = int'($urandom_range(0, 51472)) - 25736;
            if (r < 65) begin
                axis = unit_axis();
            end else if (r < 80) begin
                axis = unit_axis();
                ang  = int'($urandom_range(0, 65535));
            end else if (r < 90) begin
                axis = {16'(int'($urandom_range(0, 32768)) - 16384),
                        16'(int'($urandom_range(0, 32768)) - 16384),
                        16'(int'($urandom_range(0, 32768)) - 16384)};
            end else begin
                axis = {16'($urandom), 16'($urandom), 16'($urandom)};
                ang  = int'($urandom_range(0, 65535));
            end
            send_rotation({ang[15:0], axis},
                          !(items_sent >= BURST_FIRST && items_sent < BURST_LAST));
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("checked %0d rotation matrices: %0d directed corners, the rest random",
                 checked, directed_n);
        $display("unit and raw axes, with one long output stall and one full drain");
        if (fail_count == 0) begin
            $display("axis_angle_rotation_matrix_top: match");
        end else begin
            $display("axis_angle_rotation_matrix_top: mismatch");
        end
        $finish;
    end

endmodule

@@ axis_angle_rotation_matrix_top.f @@
+incdir+hw/rtl
hw/rtl/aarm_pkg.sv
hw/rtl/aarm_cordic.sv
hw/rtl/aarm_entry.sv
hw/rtl/aarm_skid.sv
hw/rtl/axis_angle_rotation_matrix_top.sv
dv/axis_angle_rotation_matrix_top_checker.sv
dv/axis_angle_rotation_matrix_top_test.sv
